// File: sv/ffs_pkg.sv
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared types, byte constants and frame-building functions of the fieldbus
// frame serializer.
// ----------------------------------------------------------------------------
package ffs_pkg;

   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = 5;

   localparam logic [0:0] REG_SAP = 1'b0;

   localparam logic [7:0] BYTE_SD_VAR   = 8'h68;
   localparam logic [7:0] BYTE_ED       = 8'h16;
   localparam logic [7:0] BYTE_SC_ACK   = 8'hE5;
   localparam logic [7:0] BYTE_SD_TOKEN = 8'hDC;
   localparam logic [7:0] BYTE_SD_FIXED = 8'h10;
   localparam logic [7:0] BYTE_CLOSE_FC = 8'h5C;
   localparam logic [7:0] BYTE_REQ_FC   = 8'h7C;
   localparam logic [7:0] BYTE_DSAP     = 8'h1F;
   localparam logic [7:0] BYTE_REQ_PDU  = 8'hF1;
   localparam logic [7:0] BYTE_CON_PDU  = 8'hE0;
   localparam logic [7:0] BYTE_CNF_PDU  = 8'hB0;
   localparam logic [7:0] BYTE_CLS_PDU  = 8'h80;
   localparam logic [7:0] BYTE_CNF_SPDU = 8'h05;
   localparam logic [7:0] BYTE_SEVEN    = 8'h07;
   localparam logic [7:0] BYTE_FOUR     = 8'h04;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] LEN_CONNECT   = 8'd17;
   localparam logic [7:0] LEN_CONF_S    = 8'd7;
   localparam logic [7:0] LEN_CONF_L    = 8'd8;
   localparam logic [7:0] LEN_CLOSE     = 8'd6;
   localparam logic [7:0] LEN_REQ_BASE  = 8'd7;

   typedef enum logic [2:0] {
      CMD_ACK       = 3'd0,
      CMD_TOKEN     = 3'd1,
      CMD_NO_DATA   = 3'd2,
      CMD_REQ_START = 3'd3,
      CMD_REQ_DATA  = 3'd4,
      CMD_CONNECT   = 3'd5,
      CMD_CONFIRM   = 3'd6,
      CMD_CLOSE     = 3'd7
   } ffs_cmd_type;

   typedef enum logic [3:0] {
      JOB_ACK,
      JOB_TOKEN,
      JOB_NO_DATA,
      JOB_REQ_HDR,
      JOB_REQ_DATA,
      JOB_CONNECT,
      JOB_CONF_SHORT,
      JOB_CONF_LONG,
      JOB_CLOSE
   } ffs_job_kind_type;

   typedef struct packed {
      logic [2:0] command;
      logic [6:0] dest_addr;
      logic [6:0] src_addr;
      logic [7:0] func_code;
      logic [7:0] payload_len;
      logic       confirm_long;
      logic [7:0] payload_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_last;
   } rsp_word_type;

   typedef struct packed {
      ffs_job_kind_type kind;
      logic [6:0]       dest;
      logic [6:0]       src;
      logic [7:0]       fc;
      logic [7:0]       len_byte;
      logic [7:0]       data;
      logic [7:0]       rnum;
      logic             trailer;
   } ffs_job_type;

   typedef struct packed {
      logic        push;
      ffs_job_type job;
   } ffs_push_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       frame_end;
      logic       counted;
      logic       restart;
   } ffs_byte_type;

   function automatic logic [7:0] ffs_connect_param(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd0:    r = 8'h80;
         4'd2:    r = 8'h02;
         4'd4:    r = 8'h02;
         4'd5:    r = 8'h01;
         4'd7:    r = 8'h01;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] ffs_frame_len(input ffs_job_type j);
      logic [IDX_W-1:0] n;
      unique case (j.kind)
         JOB_ACK:        n = 5'd1;
         JOB_TOKEN:      n = 5'd3;
         JOB_NO_DATA:    n = 5'd6;
         JOB_REQ_HDR:    n = j.trailer ? 5'd13 : 5'd11;
         JOB_REQ_DATA:   n = j.trailer ? 5'd3 : 5'd1;
         JOB_CONNECT:    n = 5'd23;
         JOB_CONF_SHORT: n = 5'd13;
         JOB_CONF_LONG:  n = 5'd14;
         JOB_CLOSE:      n = 5'd12;
         default:        n = 5'd1;
      endcase
      return n;
   endfunction

   // body bytes of variable-length frames, k counts from the byte after src
   function automatic logic [7:0] ffs_body(input ffs_job_type j, input logic [IDX_W-1:0] k,
                                           input logic [7:0] sap);
      logic [7:0] r;
      logic [IDX_W-1:0] t;
      t = k - 5'd6;
      r = BYTE_ZERO;
      unique case (j.kind)
         JOB_REQ_HDR: begin
            unique case (k)
               5'd0:    r = BYTE_REQ_FC;
               5'd1:    r = sap;
               5'd2:    r = BYTE_DSAP;
               5'd3:    r = BYTE_REQ_PDU;
               default: r = j.rnum;
            endcase
         end
         JOB_CONNECT: begin
            unique case (k)
               5'd0:    r = j.fc;
               5'd1:    r = BYTE_ZERO;
               5'd2:    r = BYTE_DSAP;
               5'd3:    r = BYTE_CON_PDU;
               5'd4:    r = BYTE_FOUR;
               5'd5:    r = j.rnum;
               default: r = ffs_connect_param(t[3:0]);
            endcase
         end
         JOB_CONF_SHORT: begin
            unique case (k)
               5'd0:    r = j.fc;
               5'd1:    r = sap;
               5'd2:    r = BYTE_DSAP;
               5'd3:    r = BYTE_CNF_SPDU;
               default: r = BYTE_SEVEN;
            endcase
         end
         JOB_CONF_LONG: begin
            unique case (k)
               5'd0:    r = j.fc;
               5'd1:    r = sap;
               5'd2:    r = BYTE_DSAP;
               5'd3:    r = BYTE_CNF_PDU;
               5'd4:    r = BYTE_SEVEN;
               default: r = j.rnum;
            endcase
         end
         default: begin
            unique case (k)
               5'd0:    r = BYTE_CLOSE_FC;
               5'd1:    r = sap;
               5'd2:    r = BYTE_DSAP;
               default: r = BYTE_CLS_PDU;
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic ffs_byte_type ffs_byte(input ffs_job_type j, input logic [IDX_W-1:0] idx,
                                             input logic [7:0] sap, input logic [7:0] sum);
      ffs_byte_type r;
      logic [IDX_W-1:0] n;
      logic has_trl;
      logic in_trl;
      n = ffs_frame_len(j);
      has_trl = (j.kind != JOB_REQ_HDR) || j.trailer;
      in_trl = has_trl && (idx >= n - 5'd2);
      r.data = BYTE_ZERO;
      r.last = (idx == n - 5'd1);
      // open request pieces end the job but not the frame
      r.frame_end = r.last && has_trl && ((j.kind != JOB_REQ_DATA) || j.trailer);
      r.counted = 1'b0;
      r.restart = 1'b0;
      unique case (j.kind)
         JOB_ACK: r.data = BYTE_SC_ACK;
         JOB_TOKEN: begin
            unique case (idx)
               5'd0:    r.data = BYTE_SD_TOKEN;
               5'd1:    r.data = {1'b0, j.dest};
               default: r.data = {1'b0, j.src};
            endcase
         end
         JOB_NO_DATA: begin
            unique case (idx)
               5'd0:    r.data = BYTE_SD_FIXED;
               5'd1:    r.data = {1'b0, j.dest};
               5'd2:    r.data = {1'b0, j.src};
               5'd3:    r.data = j.fc;
               5'd4:    r.data = {1'b0, j.dest} + {1'b0, j.src} + j.fc;
               default: r.data = BYTE_ED;
            endcase
         end
         JOB_REQ_DATA: begin
            unique case (idx)
               5'd0: begin
                  r.data = j.data;
                  r.counted = 1'b1;
               end
               5'd1:    r.data = sum;
               default: r.data = BYTE_ED;
            endcase
         end
         default: begin
            r.counted = (idx >= 5'd4) && !in_trl;
            r.restart = (idx == 5'd4);
            if (idx == 5'd0 || idx == 5'd3) begin
               r.data = BYTE_SD_VAR;
            end else if (idx == 5'd1 || idx == 5'd2) begin
               r.data = j.len_byte;
            end else if (idx == 5'd4) begin
               r.data = {1'b1, j.dest};
            end else if (idx == 5'd5) begin
               r.data = {1'b1, j.src};
            end else if (in_trl && r.last) begin
               r.data = BYTE_ED;
            end else if (in_trl) begin
               r.data = sum;
            end else begin
               r.data = ffs_body(j, idx - 5'd6, sap);
            end
         end
      endcase
      return r;
   endfunction

endpackage

// File: sv/ffs_front.sv
// ----------------------------------------------------------------------------
// ffs_front
// Accepts command words, tracks the open request and turns each command
// into a frame job for the byte sequencer.
// ----------------------------------------------------------------------------
module ffs_front
   import ffs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         q_full,
   output ffs_push_type push
);

   logic       open_ff,  open_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] rnum_ff,  rnum_in;
   logic [7:0] rnum_inc;
   logic       accept;
   ffs_cmd_type cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign cmd       = ffs_cmd_type'(req_word.command);
   assign rnum_inc  = rnum_ff + 8'd1;

   always_comb begin
      open_in   = open_ff;
      remain_in = remain_ff;
      rnum_in   = rnum_ff;
      push.push         = 1'b0;
      push.job.kind     = JOB_ACK;
      push.job.dest     = req_word.dest_addr;
      push.job.src      = req_word.src_addr;
      push.job.fc       = req_word.func_code;
      push.job.len_byte = BYTE_ZERO;
      push.job.data     = req_word.payload_byte;
      push.job.rnum     = rnum_ff;
      push.job.trailer  = 1'b0;
      if (accept) begin
         if (cmd == CMD_REQ_DATA) begin
            if (open_ff) begin
               push.push        = 1'b1;
               push.job.kind    = JOB_REQ_DATA;
               push.job.trailer = (remain_ff == 8'd1);
               remain_in        = remain_ff - 8'd1;
               open_in          = (remain_ff != 8'd1);
            end
         end else begin
            push.push = 1'b1;
            open_in   = 1'b0;
            remain_in = 8'd0;
            unique case (cmd)
               CMD_ACK:     push.job.kind = JOB_ACK;
               CMD_TOKEN:   push.job.kind = JOB_TOKEN;
               CMD_NO_DATA: push.job.kind = JOB_NO_DATA;
               CMD_REQ_START: begin
                  push.job.kind     = JOB_REQ_HDR;
                  push.job.len_byte = req_word.payload_len + LEN_REQ_BASE;
                  push.job.trailer  = (req_word.payload_len == 8'd0);
                  open_in           = (req_word.payload_len != 8'd0);
                  remain_in         = req_word.payload_len;
               end
               CMD_CONNECT: begin
                  push.job.kind     = JOB_CONNECT;
                  push.job.len_byte = LEN_CONNECT;
               end
               CMD_CONFIRM: begin
                  if (req_word.confirm_long) begin
                     push.job.kind     = JOB_CONF_LONG;
                     push.job.len_byte = LEN_CONF_L;
                     rnum_in           = (rnum_inc == 8'd0) ? 8'd1 : rnum_inc;
                  end else begin
                     push.job.kind     = JOB_CONF_SHORT;
                     push.job.len_byte = LEN_CONF_S;
                  end
               end
               default: begin
                  push.job.kind     = JOB_CLOSE;
                  push.job.len_byte = LEN_CLOSE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         remain_ff <= 8'd0;
         rnum_ff   <= 8'd1;
      end else begin
         open_ff   <= open_in;
         remain_ff <= remain_in;
         rnum_ff   <= rnum_in;
      end
   end

endmodule

// File: sv/ffs_queue.sv
// ----------------------------------------------------------------------------
// ffs_queue
// Short job queue between the command front end and the byte sequencer.
// ----------------------------------------------------------------------------
module ffs_queue
   import ffs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ffs_push_type push,
   input  logic         pop,
   output ffs_job_type  head_job,
   output logic         full,
   output logic         empty
);

   ffs_job_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff,  count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push.push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: sv/ffs_back.sv
// ----------------------------------------------------------------------------
// ffs_back
// Byte sequencer: walks the job at the queue head one byte per cycle unless
// output stalls, keeps the frame check sum and drives the output register.
// ----------------------------------------------------------------------------
module ffs_back
   import ffs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  ffs_job_type  head_job,
   output logic         pop,
   input  logic [7:0]   sap,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_word_ff,  out_word_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   ffs_byte_type     cur;
   logic             emit;

   assign cur       = ffs_byte(head_job, idx_ff, sap, sum_ff);
   assign emit      = !q_empty && (!out_valid_ff || rsp_ready);
   assign pop       = emit && cur.last;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      if (emit) begin
         out_valid_in           = 1'b1;
         out_word_in.tx_byte    = cur.data;
         out_word_in.frame_last = cur.frame_end;
         idx_in                 = cur.last ? '0 : idx_ff + 1'b1;
         if (cur.counted) begin
            sum_in = cur.restart ? cur.data : sum_ff + cur.data;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         sum_ff       <= 8'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

endmodule

// File: sv/fieldbus_frame_serializer_unit.sv
// ----------------------------------------------------------------------------
// fieldbus_frame_serializer_unit
// Fieldbus frame serializer: command words in, transmit bytes out.
// ----------------------------------------------------------------------------
// path: the first byte of a frame passes the job queue and then the output
//   register after its word is accepted
// throughput: one byte per cycle while a job is queued and the output is not
//   stalled; a word causes 1 to 23 bytes, or none, and the rate is set by
//   the single byte sequencer in the back end
// a new word is taken every cycle while the 4-entry job queue has room
// reset clears the queue, the output valid flag, the open request and sets
//   the request number to 1 and the sap register to 0
module fieldbus_frame_serializer_unit
   import ffs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [7:0]   sap_ff;
   logic [7:0]   sap_in;
   logic         q_full;
   logic         q_empty;
   logic         pop;
   ffs_push_type push;
   ffs_job_type  head_job;
   logic         sap_hit;

   assign pready  = 1'b1;
   assign sap_hit = (paddr[CSR_AW-1] == REG_SAP);
   assign prdata  = sap_hit ? {{(CSR_DW - 8){1'b0}}, sap_ff} : '0;
   assign sap_in  = (psel && penable && pwrite && pready && sap_hit) ? pwdata[7:0] : sap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sap_ff <= 8'd0;
      end else begin
         sap_ff <= sap_in;
      end
   end

   ffs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_full    (q_full),
      .push      (push)
   );

   ffs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   ffs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_job  (head_job),
      .pop       (pop),
      .sap       (sap_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_ack_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_word.command == CMD_ACK) |=> !q_empty)
      else $error("ack word did not reach the job queue");

   a_rsp_from_job: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_empty))
      else $error("output byte without a queued job");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("job popped from an empty queue");
`endif

endmodule

// File: bench/fieldbus_frame_serializer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fieldbus_frame_serializer_unit_tb
// Self-checking bench for the fieldbus frame serializer. Command words are
// sent in bursts with random gaps while the byte side stalls on changing
// patterns. A scoreboard builds every frame byte from its own copy of the
// request number, running sum and open request, and compares each accepted
// byte and its last marker in order. The service access point register is
// written and read back between phases, with its extremes among the values.
// ----------------------------------------------------------------------------
module fieldbus_frame_serializer_unit_tb;
   import ffs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_HOLD      = 40;
   localparam logic [CSR_AW-1:0] SAP_ADDR = CSR_AW'(4 * REG_SAP);

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   class frame_scoreboard;
      rsp_word_type bytes_due[$];
      logic [7:0]   sap;
      logic [7:0]   req_num;
      logic [7:0]   sum;
      logic [7:0]   remaining;
      bit           open;
      logic [7:0]   conn_params[9];
      int unsigned  errors;
      int unsigned  checked;

      function new();
         conn_params = '{8'h80, 8'h00, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00, 8'h01, 8'h00};
         sap       = 8'h00;
         req_num   = 8'h01;
         sum       = 8'h00;
         remaining = 8'h00;
         open      = 1'b0;
         errors    = 0;
         checked   = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic last);
         rsp_word_type r;
         r.tx_byte    = b;
         r.frame_last = last;
         bytes_due.push_back(r);
      endfunction

      function void push_summed(logic [7:0] b);
         sum = sum + b;
         push_byte(b, 1'b0);
      endfunction

      function void var_header(logic [7:0] len, logic [6:0] dest, logic [6:0] src);
         push_byte(BYTE_SD_VAR, 1'b0);
         push_byte(len, 1'b0);
         push_byte(len, 1'b0);
         push_byte(BYTE_SD_VAR, 1'b0);
         sum = 8'h00;
         push_summed({1'b1, dest});
         push_summed({1'b1, src});
      endfunction

      function void var_trailer();
         push_byte(sum, 1'b0);
         push_byte(BYTE_ED, 1'b1);
      endfunction

      // returns the number of bytes the word causes
      function int note_word(req_word_type w);
         int         queued_at_entry;
         logic [7:0] fcs;
         logic [7:0] len_byte;
         queued_at_entry = bytes_due.size();
         if (w.command == CMD_REQ_DATA) begin
            if (open) begin
               push_summed(w.payload_byte);
               remaining = remaining - 8'd1;
               if (remaining == 8'd0) begin
                  var_trailer();
                  open = 1'b0;
               end
            end
            return bytes_due.size() - queued_at_entry;
         end
         open = 1'b0;
         remaining = 8'h00;
         case (w.command)
            CMD_ACK: begin
               push_byte(BYTE_SC_ACK, 1'b1);
            end
            CMD_TOKEN: begin
               push_byte(BYTE_SD_TOKEN, 1'b0);
               push_byte({1'b0, w.dest_addr}, 1'b0);
               push_byte({1'b0, w.src_addr}, 1'b1);
            end
            CMD_NO_DATA: begin
               fcs = {1'b0, w.dest_addr} + {1'b0, w.src_addr} + w.func_code;
               push_byte(BYTE_SD_FIXED, 1'b0);
               push_byte({1'b0, w.dest_addr}, 1'b0);
               push_byte({1'b0, w.src_addr}, 1'b0);
               push_byte(w.func_code, 1'b0);
               push_byte(fcs, 1'b0);
               push_byte(BYTE_ED, 1'b1);
            end
            CMD_REQ_START: begin
               len_byte = w.payload_len + LEN_REQ_BASE;
               var_header(len_byte, w.dest_addr, w.src_addr);
               push_summed(BYTE_REQ_FC);
               push_summed(sap);
               push_summed(BYTE_DSAP);
               push_summed(BYTE_REQ_PDU);
               push_summed(req_num);
               if (w.payload_len == 8'd0) begin
                  var_trailer();
               end else begin
                  remaining = w.payload_len;
                  open = 1'b1;
               end
            end
            CMD_CONNECT: begin
               var_header(LEN_CONNECT, w.dest_addr, w.src_addr);
               push_summed(w.func_code);
               push_summed(BYTE_ZERO);
               push_summed(BYTE_DSAP);
               push_summed(BYTE_CON_PDU);
               push_summed(BYTE_FOUR);
               push_summed(req_num);
               foreach (conn_params[i]) push_summed(conn_params[i]);
               var_trailer();
            end
            CMD_CONFIRM: begin
               var_header(w.confirm_long ? LEN_CONF_L : LEN_CONF_S, w.dest_addr, w.src_addr);
               push_summed(w.func_code);
               push_summed(sap);
               push_summed(BYTE_DSAP);
               if (w.confirm_long) begin
                  push_summed(BYTE_CNF_PDU);
                  push_summed(BYTE_SEVEN);
                  push_summed(req_num);
                  req_num = req_num + 8'd1;
                  if (req_num == 8'd0) req_num = 8'd1;
               end else begin
                  push_summed(BYTE_CNF_SPDU);
                  push_summed(BYTE_SEVEN);
               end
               var_trailer();
            end
            default: begin
               var_header(LEN_CLOSE, w.dest_addr, w.src_addr);
               push_summed(BYTE_CLOSE_FC);
               push_summed(sap);
               push_summed(BYTE_DSAP);
               push_summed(BYTE_CLS_PDU);
               var_trailer();
            end
         endcase
         return bytes_due.size() - queued_at_entry;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_byte(rsp_word_type got);
         rsp_word_type want;
         if (bytes_due.size() == 0) begin
            report($sformatf("unexpected byte %h last %b", got.tx_byte, got.frame_last));
            return;
         end
         want = bytes_due.pop_front();
         checked++;
         if (got.tx_byte !== want.tx_byte)
            report($sformatf("byte %0d: tx_byte %h, want %h", checked, got.tx_byte,
                             want.tx_byte));
         if (got.frame_last !== want.frame_last)
            report($sformatf("byte %0d: frame_last %b, want %b", checked, got.frame_last,
                             want.frame_last));
      endtask
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_word_type      req_word  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_word_type      rsp_word;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   frame_scoreboard sb = new();
   int              words_sent;
   int              burst_left;
   int              sap_settings;
   int              idle_cycles;
   stall_mode_type  stall_mode  = STALL_NONE;
   int              stall_count = 0;
   int unsigned     stall_tick  = 0;

   ffs_cmd_type frame_cmds[6] = '{CMD_ACK, CMD_TOKEN, CMD_NO_DATA, CMD_CONNECT,
                                  CMD_CONFIRM, CMD_CLOSE};

   fieldbus_frame_serializer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stalls, a new random mode is drawn when the current one runs out
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_count == 0) begin
         stall_mode  <= stall_mode_type'(2'($urandom_range(0, 3)));
         stall_count <= $urandom_range(40, 300);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_ready <= 1'b1;
         STALL_RANDOM:   rsp_ready <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_ready <= (stall_tick[2:0] != 3'd0) && (stall_tick[4:3] != 2'd2);
         default:        rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_word);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("fieldbus_frame_serializer_unit regression: fail");
      $finish;
   end

   function automatic req_word_type random_word(ffs_cmd_type cmd);
      req_word_type w;
      w.command      = cmd;
      w.dest_addr    = 7'($urandom);
      w.src_addr     = 7'($urandom);
      w.func_code    = 8'($urandom);
      w.payload_len  = 8'($urandom);
      w.confirm_long = 1'($urandom);
      w.payload_byte = 8'($urandom);
      return w;
   endfunction

   function automatic req_word_type word_of(ffs_cmd_type cmd, logic [6:0] dest,
                                            logic [6:0] src, logic [7:0] fc,
                                            logic [7:0] plen, logic lng, logic [7:0] pb);
      req_word_type w;
      w.command      = cmd;
      w.dest_addr    = dest;
      w.src_addr     = src;
      w.func_code    = fc;
      w.payload_len  = plen;
      w.confirm_long = lng;
      w.payload_byte = pb;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      if (sb.note_word(w) > 0) words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // stop sending, let every owed byte out, then give the block time to settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.bytes_due.size() != 0) @(posedge clock);
      repeat (IDLE_HOLD) @(posedge clock);
   endtask

   task automatic program_sap(input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SAP_ADDR;
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.sap = value;
      sap_settings++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== value)
         sb.report($sformatf("sap register reads %h, want %h", prdata[7:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_mixed(input int target);
      int           start_count;
      int           pick;
      int           len;
      int           k;
      req_word_type w;
      start_count = words_sent;
      while (words_sent - start_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 19) == 0) len = $urandom_range(16, 40);
            else if ($urandom_range(0, 6) == 0) len = 0;
            else len = $urandom_range(1, 6);
            w = random_word(CMD_REQ_START);
            w.payload_len = 8'(len);
            send_word(w);
            repeat (len) send_word(random_word(CMD_REQ_DATA));
         end else if (pick < 67) begin
            len = $urandom_range(1, 255);
            w = random_word(CMD_REQ_START);
            w.payload_len = 8'(len);
            send_word(w);
            k = $urandom_range(0, (len > 4) ? 4 : len - 1);
            repeat (k) send_word(random_word(CMD_REQ_DATA));
         end else if (pick < 95) begin
            send_word(random_word(frame_cmds[$urandom_range(0, 5)]));
         end else begin
            send_word(random_word(CMD_REQ_DATA));
         end
      end
   endtask

   initial begin
      req_word_type w;
      words_sent   = 0;
      sap_settings = 0;
      burst_left   = 4;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset value of the sap register
      send_word(word_of(CMD_ACK, 7'h7F, 7'h7F, 8'hFF, 8'hFF, 1'b1, 8'hFF));
      send_word(word_of(CMD_TOKEN, 7'h00, 7'h00, 8'h00, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_TOKEN, 7'h7F, 7'h7F, 8'hFF, 8'hFF, 1'b1, 8'hFF));
      send_word(word_of(CMD_NO_DATA, 7'h7F, 7'h7F, 8'hFF, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_NO_DATA, 7'h00, 7'h00, 8'h00, 8'hFF, 1'b1, 8'hFF));
      send_word(word_of(CMD_REQ_START, 7'h12, 7'h34, 8'h00, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_START, 7'h55, 7'h2A, 8'hA5, 8'h02, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_DATA, 7'h00, 7'h00, 8'h00, 8'h00, 1'b0, 8'hFF));
      send_word(word_of(CMD_REQ_DATA, 7'h7F, 7'h7F, 8'hFF, 8'hFF, 1'b1, 8'h00));
      send_word(word_of(CMD_REQ_DATA, 7'h01, 7'h02, 8'h03, 8'h04, 1'b0, 8'hAB));
      send_word(word_of(CMD_REQ_START, 7'h7F, 7'h00, 8'h00, 8'hFF, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_DATA, 7'h00, 7'h00, 8'h00, 8'h00, 1'b0, 8'h81));
      send_word(word_of(CMD_REQ_START, 7'h00, 7'h7F, 8'h00, 8'd249, 1'b0, 8'h00));
      send_word(word_of(CMD_CLOSE, 7'h7F, 7'h7F, 8'h00, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_START, 7'h33, 7'h44, 8'h00, 8'h01, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_DATA, 7'h00, 7'h00, 8'h00, 8'h00, 1'b0, 8'hF0));
      send_word(word_of(CMD_CONNECT, 7'h7F, 7'h00, 8'hFF, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_CONNECT, 7'h00, 7'h7F, 8'h00, 8'h00, 1'b1, 8'h00));
      send_word(word_of(CMD_CONFIRM, 7'h21, 7'h43, 8'h08, 8'h00, 1'b0, 8'h00));
      send_word(word_of(CMD_CONFIRM, 7'h7F, 7'h7F, 8'hFF, 8'h00, 1'b1, 8'h00));
      send_word(word_of(CMD_CONFIRM, 7'h00, 7'h00, 8'h00, 8'h00, 1'b1, 8'h00));
      send_word(word_of(CMD_REQ_START, 7'h10, 7'h20, 8'h00, 8'h03, 1'b0, 8'h00));
      send_word(word_of(CMD_REQ_DATA, 7'h00, 7'h00, 8'h00, 8'h00, 1'b0, 8'h5A));
      send_word(word_of(CMD_CONFIRM, 7'h10, 7'h20, 8'h44, 8'h00, 1'b1, 8'h00));
      send_word(word_of(CMD_REQ_START, 7'h05, 7'h06, 8'h00, 8'd242, 1'b0, 8'h00));
      send_word(word_of(CMD_TOKEN, 7'h05, 7'h06, 8'h00, 8'h00, 1'b0, 8'h00));
      wait_idle();

      program_sap(8'hFF);
      run_mixed(75);
      wait_idle();

      program_sap(8'h00);
      run_mixed(75);
      wait_idle();

      // long run of long confirms so the request number wraps past zero
      program_sap(8'($urandom));
      repeat (256) begin
         w = random_word(CMD_CONFIRM);
         w.confirm_long = 1'b1;
         send_word(w);
      end
      run_mixed(10);
      wait_idle();

      $display("%0d command words with output, %0d frame bytes checked", words_sent,
               sb.checked);
      $display("%0d sap register settings, %0d mismatches", sap_settings, sb.errors);
      if (sb.errors == 0)
         $display("fieldbus_frame_serializer_unit regression: pass");
      else
         $display("fieldbus_frame_serializer_unit regression: fail");
      $finish;
   end

endmodule
